>>> src/crc16fc_pkg.sv
// crc16fc_pkg: shared types, constants and the byte-wide crc-16/modbus update
// for the crc16 frame checker; no dependencies
`timescale 1ns / 1ps

package crc16fc_pkg;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // error reply layout
    localparam logic [7:0] REPLY_MARK = 8'h3E;
    localparam logic [7:0] REPLY_LEN  = 8'd6;
    localparam int unsigned REPLY_IDX_W = 3;
    localparam logic [REPLY_IDX_W-1:0] RIDX_MARK   = 3'd0;
    localparam logic [REPLY_IDX_W-1:0] RIDX_LEN    = 3'd1;
    localparam logic [REPLY_IDX_W-1:0] RIDX_OPCODE = 3'd2;
    localparam logic [REPLY_IDX_W-1:0] RIDX_ZERO   = 3'd3;
    localparam logic [REPLY_IDX_W-1:0] RIDX_CRC_HI = 3'd4;
    localparam logic [REPLY_IDX_W-1:0] RIDX_CRC_LO = 3'd5;

    // action codes
    localparam logic [1:0] ACT_OTHER  = 2'd0;
    localparam logic [1:0] ACT_REBOOT = 2'd1;
    localparam logic [1:0] ACT_UPDATE = 2'd2;
    localparam logic [1:0] ACT_ERROR  = 2'd3;

    // configuration register indexes
    localparam logic [7:0] CFG_REBOOT = 8'd0;
    localparam logic [7:0] CFG_UPDATE = 8'd1;

    localparam logic [7:0] REBOOT_RESET = 8'd0;
    localparam logic [7:0] UPDATE_RESET = 8'd1;

    // frame byte counter, saturating
    localparam int unsigned CNT_W = 3;
    localparam logic [CNT_W-1:0] CNT_MAX = 3'd7;
    localparam logic [CNT_W-1:0] CNT_CRC_START = 3'd2;
    localparam logic [CNT_W-1:0] CNT_MIN_FRAME = 3'd4;

    // one byte into a reflected crc-16
    function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

    // reply crc after the two fixed leading bytes
    localparam logic [15:0] REPLY_SEED = crc_feed(crc_feed(CRC_INIT, REPLY_MARK), REPLY_LEN);
    // reset values of the reply crc pipeline for the reset reboot opcode
    localparam logic [15:0] REPLY_MID_RESET = crc_feed(REPLY_SEED, REBOOT_RESET);
    localparam logic [15:0] REPLY_CRC_RESET = crc_feed(REPLY_MID_RESET, 8'h00);

    typedef struct packed {
        logic [7:0]  reboot_opcode;
        logic [7:0]  update_opcode;
        logic [15:0] reply_crc;
    } cfg_t;

    typedef struct packed {
        logic       error;
        logic [1:0] action;
    } verdict_t;

endpackage

>>> src/crc16_frame_checker_core.sv
// crc16_frame_checker_core: top level of the crc-16/modbus command frame checker
// depends on crc16fc_pkg, crc16fc_cfg, crc16fc_frame, crc16fc_reply
`timescale 1ns / 1ps

// Checks command frames one byte per beat with crc-16/modbus (init 0xFFFF,
// reflected poly 0xA001); the last two bytes carry the received crc, high
// byte first, and the byte at index 2 is the command. Frame bytes are taken
// at one per cycle while no verdict waits, the crc update of one byte sitting
// between the frame state registers. A good frame gives one result beat with
// the action, passing the verdict register and then the output register. A bad
// crc or a frame under four bytes gives a six-beat error reply ('>', 6, reboot
// opcode, 0, crc high, crc low); while that reply drains from the output
// register, at most one more verdict is held and input then stalls. The reply
// crc is recomputed through mid_reg and then crc_reg after the reboot opcode
// is written. No clearing pass after reset.

module crc16_frame_checker_core (
    input  logic        clk,
    input  logic        rst_n,
    // frame byte channel
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  frame_byte,
    input  logic        end_of_frame,
    // result channel
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  action,
    output logic [7:0]  reply_byte,
    output logic        last_of_run,
    // configuration write channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    crc16fc_pkg::cfg_t      cfg;
    crc16fc_pkg::verdict_t  verd;
    logic                   verd_valid;
    logic                   verd_ready;

    assign cfg_ready = 1'b1;

    // configuration registers
    crc16fc_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    // frame crc and verdict
    crc16fc_frame u_frame (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .frame_byte   (frame_byte),
        .end_of_frame (end_of_frame),
        .cfg          (cfg),
        .verd_valid   (verd_valid),
        .verd_ready   (verd_ready),
        .verd         (verd)
    );

    // result beats
    crc16fc_reply u_reply (
        .clk         (clk),
        .rst_n       (rst_n),
        .verd_valid  (verd_valid),
        .verd_ready  (verd_ready),
        .verd        (verd),
        .cfg         (cfg),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .action      (action),
        .reply_byte  (reply_byte),
        .last_of_run (last_of_run)
    );

    // an error reply beat that is not the last is followed at once by the next
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && action == crc16fc_pkg::ACT_ERROR && !last_of_run
        |=> out_valid && action == crc16fc_pkg::ACT_ERROR)
        else $error("error reply beats not contiguous");

    // a command result is a single beat with a zero reply byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && action != crc16fc_pkg::ACT_ERROR |-> last_of_run && reply_byte == 8'h00)
        else $error("command result malformed");

    // input is held off only while a verdict waits
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> verd_valid && !verd_ready)
        else $error("input stalled without a pending verdict");

    // a taken verdict starts a result beat on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        verd_valid && verd_ready |=> out_valid)
        else $error("verdict taken but no result beat");

endmodule

>>> src/crc16fc_cfg.sv
// crc16fc_cfg: opcode registers and the precomputed crc of the error reply
// depends on crc16fc_pkg
`timescale 1ns / 1ps

module crc16fc_cfg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                wr_en,
    input  logic [7:0]          wr_index,
    input  logic [7:0]          wr_data,
    output crc16fc_pkg::cfg_t   cfg
);

    logic [7:0]  reboot_reg;
    logic [7:0]  update_reg;
    logic [15:0] mid_reg;
    logic [15:0] crc_reg;

    // opcode writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reboot_reg <= crc16fc_pkg::REBOOT_RESET;
            update_reg <= crc16fc_pkg::UPDATE_RESET;
        end
        else if (wr_en)
        begin
            if (wr_index == crc16fc_pkg::CFG_REBOOT)
                reboot_reg <= wr_data;
            else if (wr_index == crc16fc_pkg::CFG_UPDATE)
                update_reg <= wr_data;
        end
    end

    // reply crc in two steps: opcode byte, then the zero byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg <= crc16fc_pkg::REPLY_MID_RESET;
            crc_reg <= crc16fc_pkg::REPLY_CRC_RESET;
        end
        else
        begin
            mid_reg <= crc16fc_pkg::crc_feed(crc16fc_pkg::REPLY_SEED, reboot_reg);
            crc_reg <= crc16fc_pkg::crc_feed(mid_reg, 8'h00);
        end
    end

    assign cfg.reboot_opcode = reboot_reg;
    assign cfg.update_opcode = update_reg;
    assign cfg.reply_crc     = crc_reg;

endmodule

>>> src/crc16fc_frame.sv
// crc16fc_frame: per-frame crc, held bytes, command capture and the end-of-frame verdict
// depends on crc16fc_pkg
`timescale 1ns / 1ps

module crc16fc_frame (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [7:0]              frame_byte,
    input  logic                    end_of_frame,
    input  crc16fc_pkg::cfg_t       cfg,
    output logic                    verd_valid,
    input  logic                    verd_ready,
    output crc16fc_pkg::verdict_t   verd
);

    logic [15:0]                        crc_reg, crc_next;
    logic [7:0]                         held0_reg, held0_next;
    logic [7:0]                         held1_reg, held1_next;
    logic [crc16fc_pkg::CNT_W-1:0]      count_reg, count_next;
    logic [7:0]                         cmd_reg, cmd_next;
    logic                               vld_reg, vld_next;
    crc16fc_pkg::verdict_t              verd_reg, verd_next;

    logic [15:0]                        crc_upd;
    logic [7:0]                         cmd_upd;
    logic [crc16fc_pkg::CNT_W-1:0]      count_upd;
    logic                               good;
    logic                               accept;

    assign in_ready = !vld_reg || verd_ready;
    assign accept   = in_valid && in_ready;

    // state update for one beat
    always_comb
    begin
        crc_upd   = (count_reg >= crc16fc_pkg::CNT_CRC_START)
                    ? crc16fc_pkg::crc_feed(crc_reg, held0_reg) : crc_reg;
        cmd_upd   = (count_reg == crc16fc_pkg::CNT_CRC_START) ? frame_byte : cmd_reg;
        count_upd = (count_reg == crc16fc_pkg::CNT_MAX)
                    ? count_reg : count_reg + crc16fc_pkg::CNT_W'(1);
        good      = (count_upd >= crc16fc_pkg::CNT_MIN_FRAME)
                    && ({held1_reg, frame_byte} == crc_upd);

        crc_next   = crc_reg;
        held0_next = held0_reg;
        held1_next = held1_reg;
        count_next = count_reg;
        cmd_next   = cmd_reg;
        vld_next   = vld_reg && !verd_ready;
        verd_next  = verd_reg;

        if (accept)
        begin
            if (end_of_frame)
            begin
                crc_next   = crc16fc_pkg::CRC_INIT;
                held0_next = 8'h00;
                held1_next = 8'h00;
                count_next = '0;
                cmd_next   = 8'h00;
                vld_next   = 1'b1;
                verd_next.error = !good;
                if (cmd_upd == cfg.reboot_opcode)
                    verd_next.action = crc16fc_pkg::ACT_REBOOT;
                else if (cmd_upd == cfg.update_opcode)
                    verd_next.action = crc16fc_pkg::ACT_UPDATE;
                else
                    verd_next.action = crc16fc_pkg::ACT_OTHER;
            end
            else
            begin
                crc_next   = crc_upd;
                held0_next = held1_reg;
                held1_next = frame_byte;
                count_next = count_upd;
                cmd_next   = cmd_upd;
            end
        end
    end

    // frame state and verdict slot
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            crc_reg   <= crc16fc_pkg::CRC_INIT;
            held0_reg <= 8'h00;
            held1_reg <= 8'h00;
            count_reg <= '0;
            cmd_reg   <= 8'h00;
            vld_reg   <= 1'b0;
        end
        else
        begin
            crc_reg   <= crc_next;
            held0_reg <= held0_next;
            held1_reg <= held1_next;
            count_reg <= count_next;
            cmd_reg   <= cmd_next;
            vld_reg   <= vld_next;
        end
    end

    // verdict payload
    always_ff @(posedge clk)
    begin
        verd_reg <= verd_next;
    end

    assign verd_valid = vld_reg;
    assign verd       = verd_reg;

endmodule

>>> src/crc16fc_reply.sv
// crc16fc_reply: output register and the six-beat error reply sequencer
// depends on crc16fc_pkg
`timescale 1ns / 1ps

module crc16fc_reply (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    verd_valid,
    output logic                    verd_ready,
    input  crc16fc_pkg::verdict_t   verd,
    input  crc16fc_pkg::cfg_t       cfg,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [1:0]              action,
    output logic [7:0]              reply_byte,
    output logic                    last_of_run
);

    logic                                   out_valid_reg, out_valid_next;
    logic [1:0]                             action_reg, action_next;
    logic [7:0]                             byte_reg, byte_next;
    logic                                   last_reg, last_next;
    logic                                   seq_reg, seq_next;
    logic [crc16fc_pkg::REPLY_IDX_W-1:0]    idx_reg, idx_next;
    logic [7:0]                             sel_byte;
    logic                                   slot_free;

    assign slot_free  = !out_valid_reg || out_ready;
    assign verd_ready = !seq_reg && slot_free;

    // error reply byte at the current index
    always_comb
    begin
        case (idx_reg)
            crc16fc_pkg::RIDX_MARK:   sel_byte = crc16fc_pkg::REPLY_MARK;
            crc16fc_pkg::RIDX_LEN:    sel_byte = crc16fc_pkg::REPLY_LEN;
            crc16fc_pkg::RIDX_OPCODE: sel_byte = cfg.reboot_opcode;
            crc16fc_pkg::RIDX_ZERO:   sel_byte = 8'h00;
            crc16fc_pkg::RIDX_CRC_HI: sel_byte = cfg.reply_crc[15:8];
            crc16fc_pkg::RIDX_CRC_LO: sel_byte = cfg.reply_crc[7:0];
            default:                  sel_byte = 8'h00;
        endcase
    end

    // load the next beat into the output register
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        action_next    = action_reg;
        byte_next      = byte_reg;
        last_next      = last_reg;
        seq_next       = seq_reg;
        idx_next       = idx_reg;

        if (seq_reg && slot_free)
        begin
            out_valid_next = 1'b1;
            action_next    = crc16fc_pkg::ACT_ERROR;
            byte_next      = sel_byte;
            last_next      = (idx_reg == crc16fc_pkg::RIDX_CRC_LO);
            seq_next       = (idx_reg != crc16fc_pkg::RIDX_CRC_LO);
            idx_next       = idx_reg + crc16fc_pkg::REPLY_IDX_W'(1);
        end
        else if (verd_valid && verd_ready)
        begin
            out_valid_next = 1'b1;
            if (verd.error)
            begin
                action_next = crc16fc_pkg::ACT_ERROR;
                byte_next   = crc16fc_pkg::REPLY_MARK;
                last_next   = 1'b0;
                seq_next    = 1'b1;
                idx_next    = crc16fc_pkg::RIDX_LEN;
            end
            else
            begin
                action_next = verd.action;
                byte_next   = 8'h00;
                last_next   = 1'b1;
            end
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            seq_reg       <= 1'b0;
            idx_reg       <= crc16fc_pkg::RIDX_MARK;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            seq_reg       <= seq_next;
            idx_reg       <= idx_next;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        action_reg <= action_next;
        byte_reg   <= byte_next;
        last_reg   <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign action      = action_reg;
    assign reply_byte  = byte_reg;
    assign last_of_run = last_reg;

endmodule

>>> bench/crc16_frame_checker_core_tb.sv
// crc16_frame_checker_core_tb: self-checking bench for the crc-16/modbus frame checker
// depends on crc16fc_pkg and crc16_frame_checker_core
`timescale 1ns / 1ps

module crc16_frame_checker_core_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 24;
    localparam int MAX_REPORTS  = 10;
    localparam int PHASE_BYTES  = 32;
    localparam int HOLD_CYCLES  = 250;

    typedef logic [7:0] frame_t[$];

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] reply_byte;
        logic       last_of_run;
    } result_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic [7:0] frame_byte = 8'h00;
    logic       end_of_frame = 1'b0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] action;
    logic [7:0] reply_byte;
    logic       last_of_run;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_index = 8'h00;
    logic [7:0] cfg_data = 8'h00;

    // idling control
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_request = 0;
    int hold_left = 0;

    int cycle_count = 0;
    int mismatches = 0;
    int bytes_sent = 0;

    // shadow of the frame state and the opcode registers
    logic [15:0] run_crc = crc16fc_pkg::CRC_INIT;
    logic [7:0]  held [2] = '{8'h00, 8'h00};
    logic [2:0]  fb_count = '0;
    logic [7:0]  command = 8'h00;
    logic [7:0]  cur_reboot_op = crc16fc_pkg::REBOOT_RESET;
    logic [7:0]  cur_update_op = crc16fc_pkg::UPDATE_RESET;

    result_t pending_results[$];

    crc16_frame_checker_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .frame_byte   (frame_byte),
        .end_of_frame (end_of_frame),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .action       (action),
        .reply_byte   (reply_byte),
        .last_of_run  (last_of_run),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // 8 ns clock
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // bitwise reflected crc-16, one data bit per shift
    function automatic logic [15:0] modbus_crc_byte(input logic [15:0] acc,
                                                    input logic [7:0] data);
        logic [15:0] r;
        r = acc;
        for (int k = 0; k < 8; k++)
        begin
            if (r[0] ^ data[k])
                r = (r >> 1) ^ crc16fc_pkg::CRC_POLY;
            else
                r = r >> 1;
        end
        return r;
    endfunction

    // append the crc of the body, high byte first
    function automatic frame_t seal(input frame_t body);
        logic [15:0] c;
        frame_t f;
        c = crc16fc_pkg::CRC_INIT;
        f = body;
        foreach (body[i])
            c = modbus_crc_byte(c, body[i]);
        f.push_back(c[15:8]);
        f.push_back(c[7:0]);
        return f;
    endfunction

    // random body with the command at index 2
    function automatic frame_t make_body(input int len, input logic [7:0] cmd);
        frame_t f;
        for (int i = 0; i < len; i++)
            f.push_back(i == 2 ? cmd : 8'($urandom_range(255)));
        return f;
    endfunction

    // single bit error somewhere in the frame
    function automatic frame_t corrupt(input frame_t f);
        frame_t g;
        int idx;
        g = f;
        idx = $urandom_range(g.size() - 1);
        g[idx] = g[idx] ^ (8'h01 << $urandom_range(7));
        return g;
    endfunction

    // expected results of one accepted frame byte
    task automatic track_frame_byte(input logic [7:0] b, input logic eof);
        logic [15:0] reply_crc;
        logic [7:0]  reply [6];
        logic [1:0]  verdict;
        if (fb_count >= crc16fc_pkg::CNT_CRC_START)
            run_crc = modbus_crc_byte(run_crc, held[0]);
        if (fb_count == crc16fc_pkg::CNT_CRC_START)
            command = b;
        held[0] = held[1];
        held[1] = b;
        if (fb_count != crc16fc_pkg::CNT_MAX)
            fb_count++;
        if (eof)
        begin
            if (fb_count >= crc16fc_pkg::CNT_MIN_FRAME && {held[0], held[1]} == run_crc)
            begin
                // reboot wins when both opcodes match
                if (command == cur_reboot_op)
                    verdict = crc16fc_pkg::ACT_REBOOT;
                else if (command == cur_update_op)
                    verdict = crc16fc_pkg::ACT_UPDATE;
                else
                    verdict = crc16fc_pkg::ACT_OTHER;
                pending_results.push_back('{verdict, 8'h00, 1'b1});
            end
            else
            begin
                // six-byte error reply with its own crc
                reply = '{crc16fc_pkg::REPLY_MARK, crc16fc_pkg::REPLY_LEN, cur_reboot_op,
                          8'h00, 8'h00, 8'h00};
                reply_crc = crc16fc_pkg::CRC_INIT;
                for (int k = 0; k < 4; k++)
                    reply_crc = modbus_crc_byte(reply_crc, reply[k]);
                reply[4] = reply_crc[15:8];
                reply[5] = reply_crc[7:0];
                for (int k = 0; k < 6; k++)
                    pending_results.push_back('{crc16fc_pkg::ACT_ERROR, reply[k], k == 5});
            end
            run_crc = crc16fc_pkg::CRC_INIT;
            held = '{8'h00, 8'h00};
            fb_count = '0;
            command = 8'h00;
        end
    endtask

    task automatic flag_mismatch(input string what, input result_t want, input result_t got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("mismatch (%s) at %0t: expected action %0d reply %02h last %0b, %s %0d %02h %0b",
                     what, $realtime, want.action, want.reply_byte, want.last_of_run,
                     "got", got.action, got.reply_byte, got.last_of_run);
    endtask

    // monitor: check result beats, then track config and frame beats
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = '{action, reply_byte, last_of_run};
                if (pending_results.size() == 0)
                    flag_mismatch("nothing pending", '0, got);
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                        flag_mismatch("field", want, got);
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == crc16fc_pkg::CFG_REBOOT)
                    cur_reboot_op = cfg_data;
                else if (cfg_index == crc16fc_pkg::CFG_UPDATE)
                    cur_update_op = cfg_data;
            end
            if (in_valid && in_ready)
                track_frame_byte(frame_byte, end_of_frame);
        end
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ready <= 1'b0;
            hold_left--;
        end
        else if (hold_request > 0)
        begin
            out_ready <= 1'b0;
            hold_left = hold_request - 1;
            hold_request = 0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("crc16_frame_checker_core regression: fail");
            $finish;
        end
    end

    // offer one byte, idling at random first
    task automatic send_byte(input logic [7:0] b, input logic eof);
        @(negedge clk);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        frame_byte <= b;
        end_of_frame <= eof;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
    endtask

    task automatic send_frame(input frame_t f);
        foreach (f[i])
            send_byte(f[i], i == f.size() - 1);
    endtask

    task automatic write_opcode(input logic [7:0] idx, input logic [7:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // drop valid, let every expected beat arrive, then let the pipeline settle
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    // command byte that matches neither opcode
    function automatic logic [7:0] other_command();
        logic [7:0] c;
        do
            c = 8'($urandom_range(255));
        while (c == cur_reboot_op || c == cur_update_op);
        return c;
    endfunction

    // one random frame: mostly well formed, some broken, some noise
    task automatic send_random_frame();
        int pick;
        int len;
        int sel;
        logic [7:0] cmd;
        frame_t f;
        pick = $urandom_range(99);
        if ($urandom_range(19) == 0)
            len = $urandom_range(40, 12);
        else
            len = $urandom_range(9, 4);
        sel = $urandom_range(2);
        cmd = (sel == 0) ? cur_reboot_op : (sel == 1) ? cur_update_op : other_command();
        if (pick < 70)
            f = seal(make_body(len - 2, cmd));
        else if (pick < 85)
            f = corrupt(seal(make_body(len - 2, cmd)));
        else
            f = make_body($urandom_range(6, 1), 8'($urandom_range(255)));
        send_frame(f);
    endtask

    // reset opcodes: each action, byte extremes, short and bad frames
    task automatic test_directed();
        set_idling(0, 0);
        send_frame(seal(make_body(3, crc16fc_pkg::REBOOT_RESET)));
        send_frame(seal(make_body(3, crc16fc_pkg::UPDATE_RESET)));
        send_frame(seal({8'h00, 8'hFF, 8'hFF}));
        send_frame(seal({8'hFF, 8'h00}));
        send_frame({8'hFF});
        send_frame({8'h00, 8'h3E, 8'hFF});
        send_frame(corrupt(seal({8'h55, 8'hAA})));
        wait_idle();
    endtask

    // several opcode settings, extremes and equal opcodes among them
    task automatic test_opcodes();
        logic [7:0] reboot_vals [5];
        logic [7:0] update_vals [5];
        reboot_vals = '{8'hFF, 8'h00, 8'h5A, 8'hA5, 8'($urandom_range(255))};
        update_vals = '{8'h00, 8'hFF, 8'h5A, 8'h3C, 8'($urandom_range(255))};
        set_idling(35, 35);
        for (int s = 0; s < 5; s++)
        begin
            write_opcode(crc16fc_pkg::CFG_REBOOT, reboot_vals[s]);
            write_opcode(crc16fc_pkg::CFG_UPDATE, update_vals[s]);
            send_frame(seal(make_body(3, reboot_vals[s])));
            send_frame(seal(make_body(4, update_vals[s])));
            send_frame(seal(make_body(3, other_command())));
            send_frame(corrupt(seal(make_body(3, reboot_vals[s]))));
            wait_idle();
        end
    endtask

    // long receiver hold-off while error replies pile up
    task automatic test_backpressure();
        set_idling(0, 0);
        hold_request = HOLD_CYCLES;
        for (int i = 0; i < 5; i++)
        begin
            send_frame(make_body($urandom_range(2, 1), 8'h00));
            send_frame(seal(make_body(3, cur_update_op)));
        end
        wait_idle();
    endtask

    // random frames under each idling mix
    task automatic test_random();
        int send_pcts [4];
        int recv_pcts [4];
        int start;
        send_pcts = '{0, 59, 0, 35};
        recv_pcts = '{0, 0, 59, 35};
        for (int p = 0; p < 4; p++)
        begin
            set_idling(send_pcts[p], recv_pcts[p]);
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES)
                send_random_frame();
            wait_idle();
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed();
        test_opcodes();
        test_backpressure();
        test_random();
        if (mismatches == 0)
            $display("crc16_frame_checker_core regression: pass");
        else
            $display("crc16_frame_checker_core regression: fail");
        $finish;
    end

endmodule
